[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame decoder core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/ssfd_pkg.sv]
// ----------------------------------------------------------------------------
// ssfd_pkg
// Types, constants and the CRC-8 byte step for the soil sensor frame decoder.
// ----------------------------------------------------------------------------
package ssfd_pkg;

	localparam int unsigned ID_W       = 24;
	localparam int unsigned MASK_W     = 4;
	localparam int unsigned MAX_SLOTS  = 4;
	localparam int unsigned CFG_IDX_W  = 3;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WATCH_ID_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ID_ENABLE  = 3'd4;

	// Frame byte positions
	localparam logic [3:0] POS_HEADER   = 4'd0;
	localparam logic [3:0] POS_ID_FIRST = 4'd1;
	localparam logic [3:0] POS_ID_LAST  = 4'd3;
	localparam logic [3:0] POS_POWER    = 4'd4;
	localparam logic [3:0] POS_FIXED    = 4'd5;
	localparam logic [3:0] POS_MOIST    = 4'd6;
	localparam logic [3:0] POS_AD_HI    = 4'd7;
	localparam logic [3:0] POS_AD_LO    = 4'd8;
	localparam logic [3:0] POS_PAD_LO   = 4'd9;
	localparam logic [3:0] POS_PAD_HI   = 4'd11;
	localparam logic [3:0] POS_CRC      = 4'd12;
	localparam logic [3:0] POS_LAST     = 4'd13;

	localparam logic [7:0] CRC_POLY     = 8'h31;
	localparam logic [7:0] CRC_MSB      = 8'h80;
	localparam logic [7:0] HEADER_BYTE  = 8'h51;
	localparam logic [7:0] FIXED_BYTE   = 8'h7F;
	localparam logic [6:0] AD_HI_FILL   = 7'h7C;  // 0xF8 above bit 0
	localparam logic [7:0] PAD_BYTE     = 8'hFF;
	localparam logic [7:0] MOIST_MAX    = 8'd100;

	// Battery: mv = code * 100, percentage = clamp((mv - 700) / 9)
	localparam logic [4:0] BATT_CODE_ZERO = 5'd7;   // 700 mV and below reads 0 %
	localparam logic [4:0] BATT_CODE_FULL = 5'd16;  // 1600 mV and above reads 100 %
	localparam logic [4:0] BATT_CODE_LOW  = 5'd8;   // 800 mV and below is low
	localparam logic [6:0] BATT_PCT_STEP  = 7'd11;
	localparam logic [6:0] BATT_PCT_FULL  = 7'd100;
	localparam logic [6:0] MV_PER_CODE    = 7'd100;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_HEADER = 3'd1,
		ST_CHECK_FAIL = 3'd2,
		ST_UNKNOWN_ID = 3'd3,
		ST_MOIST_HIGH = 3'd4
	} status_t;

	typedef struct packed {
		logic       found;
		logic [1:0] slot;
	} id_match_t;

	// One byte through CRC-8, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Percentage from the 5-bit battery code; between the clamps it is 11 per step
	function automatic logic [6:0] batt_pct(input logic [4:0] code);
		logic [6:0] k;
		k = 7'(code - BATT_CODE_ZERO);
		if (code <= BATT_CODE_ZERO) begin
			return 7'd0;
		end else if (code >= BATT_CODE_FULL) begin
			return BATT_PCT_FULL;
		end else begin
			return 7'(k * BATT_PCT_STEP);
		end
	endfunction

endpackage

[rtl/core/ssfd_id_match.sv]
// ----------------------------------------------------------------------------
// ssfd_id_match
// Compare a sensor ID against the enabled watch slots; lowest slot wins.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssfd_id_match #(
	parameter int unsigned NUM_SLOTS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ssfd_pkg::ID_W-1:0]    id,
	input  logic [ssfd_pkg::ID_W-1:0]    watch_id [NUM_SLOTS],
	input  logic [ssfd_pkg::MASK_W-1:0]  enable_mask,
	output ssfd_pkg::id_match_t          match
);

	logic [NUM_SLOTS-1:0] hit;

	always_comb begin
		for (int n = 0; n < NUM_SLOTS; n++) begin
			hit[n] = enable_mask[n] && (watch_id[n] == id);
		end
	end

	// Walk from the top so the lowest hit is taken last
	always_comb begin
		match = '0;
		for (int n = NUM_SLOTS - 1; n >= 0; n--) begin
			if (hit[n]) begin
				match.found = 1'b1;
				match.slot  = 2'(n);
			end
		end
	end

	`ASSERT_IMPLIES(a_found_any_hit, clk, arst_n, match.found, hit != '0)
	`ASSERT_IMPLIES(a_none_no_hit, clk, arst_n, !match.found, hit == '0 && match.slot == 2'd0)
	`ASSERT_IMPLIES(a_slot_enabled, clk, arst_n, match.found, enable_mask[match.slot])

endmodule

[rtl/core/soil_sensor_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// soil_sensor_frame_decoder_core
// Byte-serial decoder for 14-byte soil sensor radio frames.
// ----------------------------------------------------------------------------
// The block takes one frame byte per input transfer and sustains one byte per
// clock while no finished result is held back. A byte is held in an input
// register, then a single pass of logic (one unrolled CRC-8 byte step, an
// 8-bit add, the ID comparators) updates the frame state and, on byte 13, loads
// the result register; out_valid is set together with that load. While a
// finished result waits with out_ready low, the input register holds and
// in_ready drops once it is full.
// frame_start restarts the byte count and drops a partial frame with no result;
// without it the count wraps after byte 13. The fixed bytes (5, 7 upper bits,
// 9 to 11) are replaced before the CRC over bytes 0 to 11 and the sum over 0
// to 12. Status reports the first failing check: header, CRC/sum, unknown ID,
// moisture over 100. Decoded fields are filled whatever the status. Watch IDs
// and the enable mask are written through the configuration port, which is
// always ready; write them only while no frame is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module soil_sensor_frame_decoder_core #(
	parameter int unsigned NUM_IDS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         rx_byte,
	input  logic                               frame_start,
	input  logic signed [8:0]                  rssi_dbm,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssfd_pkg::ID_W-1:0]          cfg_data,

	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         status,
	output logic [1:0]                         sensor_slot,
	output logic [23:0]                        node_id,
	output logic [7:0]                         moisture_pct,
	output logic [8:0]                         raw_ad,
	output logic [11:0]                        supply_mv,
	output logic [6:0]                         battery_pct,
	output logic [2:0]                         boost_level,
	output logic                               supply_low,
	output logic signed [8:0]                  rssi_out
);

	// Slots beyond the fixed four never match
	localparam int unsigned NUM_SLOTS =
		(NUM_IDS < ssfd_pkg::MAX_SLOTS) ? NUM_IDS : ssfd_pkg::MAX_SLOTS;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [ssfd_pkg::ID_W-1:0]   watch_q [NUM_SLOTS];
	logic [ssfd_pkg::MASK_W-1:0] mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				watch_q[i] <= '0;
			end
			mask_q <= '0;
		end else if (cfg_valid) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (cfg_index == ssfd_pkg::REG_WATCH_ID_0 + ssfd_pkg::CFG_IDX_W'(i)) begin
					watch_q[i] <= cfg_data;
				end
			end
			if (cfg_index == ssfd_pkg::REG_ID_ENABLE) begin
				mask_q <= cfg_data[ssfd_pkg::MASK_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;
	logic signed [8:0] rssi_s1;
	logic              stall;
	logic              fire;

	// Hold everything while a finished result waits to be taken
	assign stall    = out_valid && !out_ready;
	assign fire     = valid_s1 && !stall;
	assign in_ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
			rssi_s1  <= rssi_dbm;
		end
	end

	// ------------------------------------------------------------------
	// Frame state
	// ------------------------------------------------------------------
	logic [3:0]  pos_q;
	logic [7:0]  crc_q;
	logic [7:0]  sum_q;
	logic        header_q;
	logic [23:0] id_q;
	logic [7:0]  power_q;
	logic [7:0]  moist_q;
	logic [8:0]  ad_q;
	logic [7:0]  crc_byte_q;

	logic [3:0]  pos;
	logic [7:0]  nb;
	logic [7:0]  crc_base;
	logic [7:0]  sum_base;
	logic        last;

	always_comb begin
		pos = start_s1 ? ssfd_pkg::POS_HEADER : pos_q;
		if (pos > ssfd_pkg::POS_LAST) begin
			pos = ssfd_pkg::POS_HEADER;
		end

		// Replace the bytes that the check covers with fixed values
		nb = byte_s1;
		if (pos == ssfd_pkg::POS_FIXED) begin
			nb = ssfd_pkg::FIXED_BYTE;
		end else if (pos == ssfd_pkg::POS_AD_HI) begin
			nb = {ssfd_pkg::AD_HI_FILL, byte_s1[0]};
		end else if (pos >= ssfd_pkg::POS_PAD_LO && pos <= ssfd_pkg::POS_PAD_HI) begin
			nb = ssfd_pkg::PAD_BYTE;
		end

		crc_base = (pos == ssfd_pkg::POS_HEADER) ? 8'h00 : crc_q;
		sum_base = (pos == ssfd_pkg::POS_HEADER) ? 8'h00 : sum_q;
		last     = (pos == ssfd_pkg::POS_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			crc_q      <= '0;
			sum_q      <= '0;
			header_q   <= 1'b0;
			id_q       <= '0;
			power_q    <= '0;
			moist_q    <= '0;
			ad_q       <= '0;
			crc_byte_q <= '0;
		end else if (fire) begin
			pos_q <= last ? ssfd_pkg::POS_HEADER : 4'(pos + 4'd1);

			if (pos <= ssfd_pkg::POS_PAD_HI) begin
				crc_q <= ssfd_pkg::crc8_step(crc_base, nb);
			end else begin
				crc_q <= crc_base;
			end
			if (pos <= ssfd_pkg::POS_CRC) begin
				sum_q <= 8'(sum_base + nb);
			end else begin
				sum_q <= sum_base;
			end

			if (pos == ssfd_pkg::POS_HEADER) begin
				header_q <= (byte_s1 == ssfd_pkg::HEADER_BYTE);
				id_q     <= '0;
			end else if (pos >= ssfd_pkg::POS_ID_FIRST && pos <= ssfd_pkg::POS_ID_LAST) begin
				id_q <= {id_q[15:0], byte_s1};
			end

			if (pos == ssfd_pkg::POS_POWER) begin
				power_q <= byte_s1;
			end
			if (pos == ssfd_pkg::POS_MOIST) begin
				moist_q <= byte_s1;
			end
			if (pos == ssfd_pkg::POS_AD_HI) begin
				ad_q <= {byte_s1[0], 8'h00};
			end else if (pos == ssfd_pkg::POS_AD_LO) begin
				ad_q <= {ad_q[8], byte_s1};
			end
			if (pos == ssfd_pkg::POS_CRC) begin
				crc_byte_q <= byte_s1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result
	// ------------------------------------------------------------------
	ssfd_pkg::id_match_t match;
	ssfd_pkg::status_t   status_d;

	ssfd_id_match #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_id_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.id          (id_q),
		.watch_id    (watch_q),
		.enable_mask (mask_q),
		.match       (match)
	);

	always_comb begin
		if (!header_q) begin
			status_d = ssfd_pkg::ST_BAD_HEADER;
		end else if (crc_q != crc_byte_q || sum_q != byte_s1) begin
			status_d = ssfd_pkg::ST_CHECK_FAIL;
		end else if (!match.found) begin
			status_d = ssfd_pkg::ST_UNKNOWN_ID;
		end else if (moist_q > ssfd_pkg::MOIST_MAX) begin
			status_d = ssfd_pkg::ST_MOIST_HIGH;
		end else begin
			status_d = ssfd_pkg::ST_OK;
		end
	end

	logic load;
	assign load = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status       <= status_d;
			sensor_slot  <= match.slot;
			node_id      <= id_q;
			moisture_pct <= moist_q;
			raw_ad       <= ad_q;
			supply_mv    <= 12'(power_q[4:0]) * 12'(ssfd_pkg::MV_PER_CODE);
			battery_pct  <= ssfd_pkg::batt_pct(power_q[4:0]);
			boost_level  <= power_q[7:5];
			supply_low   <= (power_q[4:0] <= ssfd_pkg::BATT_CODE_LOW);
			rssi_out     <= rssi_s1;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_ALWAYS(a_pos_range, clk, arst_n, pos_q <= ssfd_pkg::POS_LAST)
	`ASSERT_NEXT(a_wrap_after_last, clk, arst_n, load, pos_q == ssfd_pkg::POS_HEADER && out_valid)
	`ASSERT_IMPLIES(a_ready_only_stall, clk, arst_n, !in_ready, valid_s1 && out_valid)
	`ASSERT_IMPLIES(a_ok_moisture, clk, arst_n,
		out_valid && status == ssfd_pkg::ST_OK, moisture_pct <= ssfd_pkg::MOIST_MAX)
	`ASSERT_IMPLIES(a_pct_range, clk, arst_n, out_valid, battery_pct <= ssfd_pkg::BATT_PCT_FULL)

endmodule

[test/ssfd_frame_checker.sv]
// ----------------------------------------------------------------------------
// ssfd_frame_checker
// Watches the byte, configuration and result channels of the frame decoder,
// predicts one status record per completed frame and compares each result.
// ----------------------------------------------------------------------------
module ssfd_frame_checker
	import ssfd_pkg::*;
#(
	parameter int unsigned NUM_IDS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [7:0]           rx_byte,
	input  logic                 frame_start,
	input  logic signed [8:0]    rssi_dbm,

	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ID_W-1:0]      cfg_data,

	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [2:0]           status,
	input  logic [1:0]           sensor_slot,
	input  logic [23:0]          node_id,
	input  logic [7:0]           moisture_pct,
	input  logic [8:0]           raw_ad,
	input  logic [11:0]          supply_mv,
	input  logic [6:0]           battery_pct,
	input  logic [2:0]           boost_level,
	input  logic                 supply_low,
	input  logic signed [8:0]    rssi_out,

	output int unsigned          fail_count,
	output int unsigned          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t     status;
		logic [1:0]  slot;
		logic [23:0] id;
		logic [7:0]  moisture;
		logic [8:0]  ad;
		logic [11:0] mv;
		logic [6:0]  pct;
		logic [2:0]  boost;
		logic        low;
		logic [8:0]  rssi;
	} frame_report_t;

	logic [ID_W-1:0]   watch_copy [MAX_SLOTS];
	logic [MASK_W-1:0] enable_copy;

	logic [3:0]  next_pos;
	logic [7:0]  crc_acc;
	logic [7:0]  sum_acc;
	logic        hdr_seen;
	logic [23:0] id_acc;
	logic [7:0]  power_hold;
	logic [7:0]  moist_hold;
	logic [8:0]  ad_hold;
	logic [7:0]  crc_rx;

	frame_report_t pending_reports [$];
	frame_report_t oldest_report;
	int unsigned   errors = 0;

	function automatic logic [7:0] crc_advance(input logic [7:0] c_in, input logic [7:0] d);
		logic [7:0] c;
		c = c_in ^ d;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	// advance the frame state by one byte; queue a record on the last byte
	task automatic decode_byte(input logic [7:0] b, input logic st, input logic [8:0] r);
		logic [3:0]    p;
		logic [7:0]    nb;
		int unsigned   mvi;
		int unsigned   q;
		logic          hit;
		logic [1:0]    slot;
		frame_report_t rep;

		p = st ? POS_HEADER : next_pos;
		if (p > POS_LAST) p = POS_HEADER;

		nb = b;
		if (p == POS_FIXED) nb = FIXED_BYTE;
		else if (p == POS_AD_HI) nb = {AD_HI_FILL, b[0]};
		else if (p >= POS_PAD_LO && p <= POS_PAD_HI) nb = PAD_BYTE;

		if (p == POS_HEADER) begin
			crc_acc  = '0;
			sum_acc  = '0;
			id_acc   = '0;
			hdr_seen = (b == HEADER_BYTE);
		end
		if (p <= POS_PAD_HI) crc_acc = crc_advance(crc_acc, nb);
		if (p <= POS_CRC) sum_acc = sum_acc + nb;

		if (p >= POS_ID_FIRST && p <= POS_ID_LAST) id_acc = {id_acc[15:0], b};
		else if (p == POS_POWER) power_hold = b;
		else if (p == POS_MOIST) moist_hold = b;
		else if (p == POS_AD_HI) ad_hold = {b[0], 8'h00};
		else if (p == POS_AD_LO) ad_hold = {ad_hold[8], b};
		else if (p == POS_CRC) crc_rx = b;

		if (p != POS_LAST) begin
			next_pos = p + 4'd1;
		end else begin
			next_pos = POS_HEADER;
			hit = 1'b0;
			slot = '0;
			for (int n = 0; n < MAX_SLOTS && n < NUM_IDS; n++) begin
				if (!hit && enable_copy[n] && watch_copy[n] == id_acc) begin
					hit = 1'b1;
					slot = 2'(n);
				end
			end

			if (!hdr_seen) rep.status = ST_BAD_HEADER;
			else if (crc_acc != crc_rx || sum_acc != b) rep.status = ST_CHECK_FAIL;
			else if (!hit) rep.status = ST_UNKNOWN_ID;
			else if (moist_hold > MOIST_MAX) rep.status = ST_MOIST_HIGH;
			else rep.status = ST_OK;

			mvi = power_hold[4:0] * 100;
			if (mvi <= 700) begin
				q = 0;
			end else begin
				q = (mvi - 700) / 9;
				if (q > 100) q = 100;
			end

			rep.slot     = slot;
			rep.id       = id_acc;
			rep.moisture = moist_hold;
			rep.ad       = ad_hold;
			rep.mv       = 12'(mvi);
			rep.pct      = 7'(q);
			rep.boost    = power_hold[7:5];
			rep.low      = (mvi <= 800);
			rep.rssi     = r;
			pending_reports.insert(pending_reports.size(), rep);
		end
	endtask

	task automatic check_report(input frame_report_t want);
		if (status !== 3'(want.status))
			flag_mismatch($sformatf("status: got %0d, expected %0d", status, want.status));
		if (sensor_slot !== want.slot)
			flag_mismatch($sformatf("sensor_slot: got %0d, expected %0d",
				sensor_slot, want.slot));
		if (node_id !== want.id)
			flag_mismatch($sformatf("node_id: got %06h, expected %06h", node_id, want.id));
		if (moisture_pct !== want.moisture)
			flag_mismatch($sformatf("moisture_pct: got %0d, expected %0d",
				moisture_pct, want.moisture));
		if (raw_ad !== want.ad)
			flag_mismatch($sformatf("raw_ad: got %0d, expected %0d", raw_ad, want.ad));
		if (supply_mv !== want.mv)
			flag_mismatch($sformatf("supply_mv: got %0d, expected %0d", supply_mv, want.mv));
		if (battery_pct !== want.pct)
			flag_mismatch($sformatf("battery_pct: got %0d, expected %0d",
				battery_pct, want.pct));
		if (boost_level !== want.boost)
			flag_mismatch($sformatf("boost_level: got %0d, expected %0d",
				boost_level, want.boost));
		if (supply_low !== want.low)
			flag_mismatch($sformatf("supply_low: got %0d, expected %0d",
				supply_low, want.low));
		if ($unsigned(rssi_out) !== want.rssi)
			flag_mismatch($sformatf("rssi_out: got %03h, expected %03h", rssi_out, want.rssi));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SLOTS; s++) watch_copy[s] = '0;
			enable_copy = '0;
			next_pos    = POS_HEADER;
			crc_acc     = '0;
			sum_acc     = '0;
			hdr_seen    = 1'b0;
			id_acc      = '0;
			power_hold  = '0;
			moist_hold  = '0;
			ad_hold     = '0;
			crc_rx      = '0;
			pending_reports.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					flag_mismatch($sformatf("result with none expected: status %0d, id %06h",
						status, node_id));
				end else begin
					oldest_report = pending_reports[0];
					pending_reports.delete(0);
					check_report(oldest_report);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < MAX_SLOTS) begin
					if (cfg_index < NUM_IDS) watch_copy[cfg_index[1:0]] = cfg_data;
				end else if (cfg_index == REG_ID_ENABLE) begin
					enable_copy = cfg_data[MASK_W-1:0];
				end
			end
			if (in_valid && in_ready) decode_byte(rx_byte, frame_start, rssi_dbm);
		end
		fail_count  <= errors;
		outstanding <= pending_reports.size();
	end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives byte frames and watch-list writes into the soil sensor frame decoder
// under random sender and receiver stalls; the checker beside it predicts and
// compares every status record, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ssfd_pkg::*;

	localparam int unsigned ID_SLOTS         = 4;
	localparam int unsigned DRAIN_CYCLES     = 8;     // result shows after byte 13 passes the input and result registers
	localparam int unsigned STALL_LIMIT      = 4000;  // cycles with no transfer at all
	localparam int unsigned FRAMES_PER_PHASE = 22;

	typedef logic [13:0][7:0] frame_t;

	logic                 clk;
	logic                 arst_n       = 1'b0;

	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte      = '0;
	logic                 frame_start  = 1'b0;
	logic signed [8:0]    rssi_dbm     = '0;

	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [ID_W-1:0]      cfg_data     = '0;

	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [2:0]           status;
	logic [1:0]           sensor_slot;
	logic [23:0]          node_id;
	logic [7:0]           moisture_pct;
	logic [8:0]           raw_ad;
	logic [11:0]          supply_mv;
	logic [6:0]           battery_pct;
	logic [2:0]           boost_level;
	logic                 supply_low;
	logic signed [8:0]    rssi_out;

	int unsigned          fail_count;
	int unsigned          outstanding;

	// stall odds in percent per cycle, changed between phases
	int unsigned          in_idle_pct   = 0;
	int unsigned          out_stall_pct = 0;
	int unsigned          idle_run      = 0;

	// identifiers last written, so that most frames can name a watched sensor
	logic [ID_W-1:0]      ids_set [ID_SLOTS];

	soil_sensor_frame_decoder_core #(
		.NUM_IDS(ID_SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.rssi_dbm    (rssi_dbm),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.sensor_slot (sensor_slot),
		.node_id     (node_id),
		.moisture_pct(moisture_pct),
		.raw_ad      (raw_ad),
		.supply_mv   (supply_mv),
		.battery_pct (battery_pct),
		.boost_level (boost_level),
		.supply_low  (supply_low),
		.rssi_out    (rssi_out)
	);

	ssfd_frame_checker #(
		.NUM_IDS(ID_SLOTS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.rssi_dbm    (rssi_dbm),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.sensor_slot (sensor_slot),
		.node_id     (node_id),
		.moisture_pct(moisture_pct),
		.raw_ad      (raw_ad),
		.supply_mv   (supply_mv),
		.battery_pct (battery_pct),
		.boost_level (boost_level),
		.supply_low  (supply_low),
		.rssi_out    (rssi_out),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver side: hold off results at random, at the rate of the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
		end
	end

	// Watchdog: any transfer on any channel restarts the count; a long silence
	// means the block has hung, so give up with a failure.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_run <= 0;
		end else if (idle_run >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	// Byte as it enters the CRC and the sum: the fixed positions are forced.
	function automatic logic [7:0] line_byte(input int unsigned pos, input logic [7:0] b);
		if (pos == POS_FIXED) return FIXED_BYTE;
		if (pos == POS_AD_HI) return {AD_HI_FILL, b[0]};
		if (pos >= POS_PAD_LO && pos <= POS_PAD_HI) return PAD_BYTE;
		return b;
	endfunction

	// Fill in the CRC byte and the trailing sum so that the frame checks out.
	function automatic frame_t seal(input frame_t f);
		logic [7:0] c;
		logic [7:0] s;
		c = '0;
		for (int k = 0; k <= POS_PAD_HI; k++) begin
			c = c ^ line_byte(k, f[k]);
			for (int i = 0; i < 8; i++) begin
				c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
			end
		end
		f[POS_CRC] = c;
		s = '0;
		for (int k = 0; k <= POS_CRC; k++) s = s + line_byte(k, f[k]);
		f[POS_LAST] = s;
		return f;
	endfunction

	// Mostly the sensor's real span, now and then any 9-bit pattern.
	function automatic logic signed [8:0] pick_rssi();
		int k;
		k = $urandom_range(0, 160);
		if ($urandom_range(0, 9) < 7) return 9'(-k);
		return 9'($urandom);
	endfunction

	// Offer one byte, idling first at the phase's rate; return once it has
	// been transferred. Valid stays high into the next byte unless we idle.
	task automatic send_byte(input logic [7:0] b, input logic st, input logic signed [8:0] r);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		rx_byte     <= b;
		frame_start <= st;
		rssi_dbm    <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Send a whole frame; without a start mark byte 0 relies on the wrap.
	task automatic send_frame(input frame_t f, input logic mark, input logic signed [8:0] tail);
		for (int k = 0; k < POS_LAST; k++) send_byte(f[k], mark && (k == 0), pick_rssi());
		send_byte(f[POS_LAST], 1'b0, tail);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Write all four identifiers from ids_set, then the enable mask with junk
	// in the upper data bits, which the block must drop.
	task automatic load_watch_list(input logic [MASK_W-1:0] mask);
		for (int s = 0; s < ID_SLOTS; s++) write_reg(CFG_IDX_W'(REG_WATCH_ID_0 + s), ids_set[s]);
		write_reg(REG_ID_ENABLE, {20'($urandom), mask});
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, let every expected record drain, then keep clocking the
	// pipeline so that nothing is left in flight.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Well-formed frame with random content, now and then broken in one way:
	// bad header, bad CRC byte or bad sum.
	task automatic random_frame(input logic force_mark);
		frame_t      f;
		logic [23:0] id;
		int unsigned roll;
		for (int k = 0; k < 14; k++) f[k] = 8'($urandom);
		if ($urandom_range(0, 9) < 8) id = ids_set[$urandom_range(0, ID_SLOTS - 1)];
		else id = 24'($urandom);
		f[POS_HEADER] = HEADER_BYTE;
		f[1] = id[23:16];
		f[2] = id[15:8];
		f[3] = id[7:0];
		if ($urandom_range(0, 99) < 85) f[POS_MOIST] = 8'($urandom_range(0, 100));
		else f[POS_MOIST] = 8'($urandom_range(101, 255));
		f = seal(f);
		roll = $urandom_range(0, 99);
		if (roll < 8) f[POS_HEADER] = f[POS_HEADER] ^ 8'($urandom_range(1, 255));
		else if (roll < 16) f[POS_CRC] = f[POS_CRC] ^ 8'($urandom_range(1, 255));
		else if (roll < 24) f[POS_LAST] = f[POS_LAST] ^ 8'($urandom_range(1, 255));
		send_frame(f, force_mark || ($urandom_range(0, 4) != 0), pick_rssi());
	endtask

	// Raw bytes with stray start marks: partial frames, restarts, junk.
	task automatic noise_burst();
		int unsigned len;
		len = $urandom_range(1, 20);
		repeat (len) send_byte(8'($urandom), $urandom_range(0, 7) == 0, pick_rssi());
	endtask

	// Close every phase with a marked, whole frame so the byte count is back
	// at zero before the watch list changes.
	task automatic run_phase();
		repeat (FRAMES_PER_PHASE) begin
			if ($urandom_range(0, 9) == 0) noise_burst();
			else random_frame(1'b0);
		end
		random_frame(1'b1);
	endtask

	initial begin
		frame_t f;

		for (int s = 0; s < ID_SLOTS; s++) ids_set[s] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_pct   = 34;
		out_stall_pct = 82;

		// Partial frame, then a restart mark on a new frame: the partial one
		// must vanish without a result.
		for (int k = 0; k < 6; k++) send_byte(k == 0 ? HEADER_BYTE : 8'h00, k == 0, 9'sd0);

		// All-ones frame under the reset watch list: identifier 0 sits in
		// slot 0 but no slot is enabled, so it must come back unknown.
		f = '1;
		f[POS_HEADER] = HEADER_BYTE;
		f[1] = 8'h00;
		f[2] = 8'h00;
		f[3] = 8'h00;
		f = seal(f);
		send_frame(f, 1'b1, -9'sd160);
		settle();

		// Extreme identifiers, every slot enabled.
		ids_set[0] = 24'h000000;
		ids_set[1] = 24'hFFFFFF;
		ids_set[2] = 24'($urandom);
		ids_set[3] = 24'($urandom);
		load_watch_list(4'hF);
		run_phase();
		settle();

		// Swap the stall odds. Slots 1 and 2 share an identifier, so the
		// lower slot must win.
		in_idle_pct   = 82;
		out_stall_pct = 34;
		ids_set[0] = 24'($urandom);
		ids_set[1] = 24'($urandom);
		ids_set[2] = ids_set[1];
		ids_set[3] = 24'($urandom);
		load_watch_list({1'($urandom), 3'b110});
		run_phase();
		settle();

		// No stalls on either side, only the outer slots enabled.
		in_idle_pct   = 0;
		out_stall_pct = 0;
		for (int s = 0; s < ID_SLOTS; s++) ids_set[s] = 24'($urandom);
		load_watch_list(4'b1001);
		run_phase();
		settle();

		if (fail_count == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ssfd_pkg.sv
rtl/core/ssfd_id_match.sv
rtl/core/soil_sensor_frame_decoder_core.sv
test/ssfd_frame_checker.sv
test/testbench.sv
